// ----- hdl/icdr_pkg.sv -----
// Shared constants, types and helpers of the chunk resolution rewriter.
package icdr_pkg;

  localparam int MAX_DEPTH     = 8;
  localparam int POSITION_BITS = 32;

  localparam int POS_W = POSITION_BITS;
  localparam int END_W = POSITION_BITS + 1;
  localparam int LVL_W = $clog2(MAX_DEPTH + 1);
  localparam int IDX_W = $clog2(MAX_DEPTH);
  localparam int SUM_W = ((END_W > 32) ? END_W : 32) + 1;

  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam logic [END_W-1:0] END_MAX = '1;

  localparam logic [31:0] ID_FORM  = 32'h464f524d;
  localparam logic [31:0] ID_INFO  = 32'h494e464f;
  localparam logic [31:0] ID_MAGIC = 32'h41542654;
  localparam logic [31:0] FORM_A   = 32'h444a5655;
  localparam logic [31:0] FORM_B   = 32'h444a564d;

  localparam logic [11:0] DPI_RESET = 12'd300;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_END  = 2'd1;
  localparam logic [1:0] ERR_LEN  = 2'd2;
  localparam logic [1:0] ERR_DEEP = 2'd3;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_ID,
    PH_LEN_FORM,
    PH_LEN_INFO,
    PH_LEN_OTHER,
    PH_FORMID
  } phase_t;

  // One stacked form: its end, and where popping it leads (position, level)
  typedef struct packed {
    logic [END_W-1:0] end_pos;
    logic [END_W-1:0] chain_pos;
    logic [LVL_W-1:0] chain_lvl;
  } stk_entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    stk_entry_t       entry;
  } stk_wr_t;

  function automatic logic [END_W-1:0] pad_even(input logic [END_W-1:0] x);
    return x + END_W'(x[0]);
  endfunction

endpackage

// ----- hdl/icdr_if.sv -----
// Channel interfaces: input bytes, result bytes and the resolution write port.
interface icdr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;
  modport source (output valid, in_byte, last_byte, input ready);
  modport sink (input valid, in_byte, last_byte, output ready);
endinterface

interface icdr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       replaced;
  logic [1:0] error_code;
  logic       end_flag;
  modport source (output valid, out_byte, replaced, error_code, end_flag, input ready);
  modport sink (input valid, out_byte, replaced, error_code, end_flag, output ready);
endinterface

interface icdr_cfg_if;
  logic        valid;
  logic        ready;
  logic [11:0] new_dpi;
  modport source (output valid, new_dpi, input ready);
  modport sink (input valid, new_dpi, output ready);
endinterface

// ----- hdl/icdr_end_stack.sv -----
// Register stack of open form ends with one write and one read port.
module icdr_end_stack (
  input  logic                         clk,
  input  icdr_pkg::stk_wr_t            wr,
  input  logic [icdr_pkg::IDX_W-1:0]   rd_idx,
  output icdr_pkg::stk_entry_t         rd_entry
);

  icdr_pkg::stk_entry_t stk_r [icdr_pkg::MAX_DEPTH];

  // write pushed entry
  always_ff @(posedge clk) begin
    if (wr.en) begin
      stk_r[wr.idx] <= wr.entry;
    end
  end

  // read the entry that becomes top after a pop
  assign rd_entry = stk_r[rd_idx];

endmodule

// ----- hdl/iff_chunk_dpi_rewriter_core.sv -----
// Top level: chunk walker that rewrites the resolution field of info chunks.
// An item is held in the input register, then in the result register, until it leaves.
// Throughput: one item per cycle unless the output stalls; the whole parse step sits between
// the input register and the result register, with one read of the form-end stack per item.
// Reset: synchronous on rst_n low; clears parser state and sets the resolution to 300.
// The form-end stack is not cleared; only entries below the stack level are read.
module iff_chunk_dpi_rewriter_core (
  input  logic       clk,
  input  logic       rst_n,
  icdr_in_if.sink    in_chan,
  icdr_out_if.source out_chan,
  icdr_cfg_if.sink   cfg_chan
);

  // input stage
  logic       s1_v_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_adv;

  // result stage
  logic       out_v_r;
  logic [7:0] out_byte_r;
  logic       out_rep_r;
  logic [1:0] out_err_r;
  logic       out_end_r;

  // configuration and parser state
  logic [11:0]                  dpi_r;
  logic [icdr_pkg::POS_W-1:0]   pos_r;
  logic [31:0]                  hs_r, hs_nxt;
  icdr_pkg::phase_t             phase_r, phase_nxt;
  logic [1:0]                   hcnt_r, hcnt_nxt;
  logic [icdr_pkg::END_W-1:0]   nhp_r, nhp_nxt;
  logic [icdr_pkg::LVL_W-1:0]   level_r, level_nxt;
  icdr_pkg::stk_entry_t         top_r, top_nxt;
  logic                         info_pend_r, info_pend_nxt;
  logic [icdr_pkg::END_W-1:0]   info_pos_r, info_pos_nxt;
  logic [1:0]                   err_r, err_nxt;

  logic [7:0] byte_nxt;
  logic       rep_nxt;

  icdr_pkg::stk_wr_t            stk_wr;
  logic [icdr_pkg::IDX_W-1:0]   stk_rd_idx;
  icdr_pkg::stk_entry_t         stk_rd;

  // handshake
  assign s1_adv         = s1_v_r && (!out_v_r || out_chan.ready);
  assign in_chan.ready  = !s1_v_r || s1_adv;
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid      = out_v_r;
  assign out_chan.out_byte   = out_byte_r;
  assign out_chan.replaced   = out_rep_r;
  assign out_chan.error_code = out_err_r;
  assign out_chan.end_flag   = out_end_r;

  icdr_end_stack u_stack (
    .clk      (clk),
    .wr       (stk_wr),
    .rd_idx   (stk_rd_idx),
    .rd_entry (stk_rd)
  );

  // parse one byte: replacement, header walk, form close, end check
  always_comb begin
    logic [icdr_pkg::END_W-1:0] posx;
    logic [icdr_pkg::END_W-1:0] info_lo, info_hi;
    logic [icdr_pkg::END_W-1:0] gn_t, tt, pad_nhp, chunk_end;
    logic [icdr_pkg::SUM_W-1:0] sum;
    logic [icdr_pkg::LVL_W-1:0] cand_lvl, new_lvl;
    icdr_pkg::stk_entry_t       new_entry, cand_top;
    logic                       run, complete, gn, push, pop, chained;

    posx          = {1'b0, pos_r};
    byte_nxt      = s1_byte_r;
    rep_nxt       = 1'b0;
    err_nxt       = err_r;
    info_pend_nxt = info_pend_r;
    info_pos_nxt  = info_pos_r;
    hs_nxt        = hs_r;
    phase_nxt     = phase_r;
    hcnt_nxt      = hcnt_r;
    nhp_nxt       = nhp_r;
    level_nxt     = level_r;
    top_nxt       = top_r;
    run           = 1'b0;
    complete      = 1'b0;
    gn            = 1'b0;
    gn_t          = '0;
    push          = 1'b0;
    sum           = '0;
    chunk_end     = '0;
    info_lo       = info_pos_r + icdr_pkg::END_W'(6);
    info_hi       = info_pos_r + icdr_pkg::END_W'(7);

    // overwrite the two resolution bytes of a pending info chunk
    if (err_r == icdr_pkg::ERR_NONE && info_pend_r) begin
      if (s1_last_r && info_hi > posx) begin
        err_nxt = icdr_pkg::ERR_END;
      end else if (posx == info_lo) begin
        byte_nxt = dpi_r[7:0];
        rep_nxt  = 1'b1;
      end else if (posx == info_hi) begin
        byte_nxt      = {4'h0, dpi_r[11:8]};
        rep_nxt       = 1'b1;
        info_pend_nxt = 1'b0;
      end else if (posx > info_hi) begin
        info_pend_nxt = 1'b0;
      end
    end

    // entry to push for an accepted form, with its pop chain
    pad_nhp             = icdr_pkg::pad_even(nhp_r);
    chained             = (level_r != '0) && (pad_nhp >= top_r.end_pos);
    new_entry.end_pos   = nhp_r;
    new_entry.chain_pos = chained ? top_r.chain_pos : pad_nhp;
    new_entry.chain_lvl = chained ? top_r.chain_lvl : level_r;

    // collect header bytes
    if (err_nxt == icdr_pkg::ERR_NONE) begin
      run = 1'b1;
      if (phase_r == icdr_pkg::PH_WAIT) begin
        if (posx != nhp_r) begin
          run = 1'b0;
        end else begin
          phase_nxt = icdr_pkg::PH_ID;
          hcnt_nxt  = 2'd0;
          hs_nxt    = '0;
        end
      end
      if (run) begin
        hs_nxt = {hs_nxt[23:0], byte_nxt};
        if (hcnt_nxt == 2'd3) begin
          hcnt_nxt = 2'd0;
          complete = 1'b1;
        end else begin
          hcnt_nxt = hcnt_nxt + 2'd1;
        end
      end
    end

    // act on a complete header word
    if (complete) begin
      case (phase_nxt)
        icdr_pkg::PH_ID: begin
          if (hs_nxt == icdr_pkg::ID_MAGIC) begin
            gn   = 1'b1;
            gn_t = icdr_pkg::pad_even(posx + icdr_pkg::END_W'(1));
          end else if (hs_nxt == icdr_pkg::ID_FORM) begin
            phase_nxt = icdr_pkg::PH_LEN_FORM;
          end else if (hs_nxt == icdr_pkg::ID_INFO) begin
            phase_nxt = icdr_pkg::PH_LEN_INFO;
          end else begin
            phase_nxt = icdr_pkg::PH_LEN_OTHER;
          end
        end
        icdr_pkg::PH_LEN_FORM, icdr_pkg::PH_LEN_INFO, icdr_pkg::PH_LEN_OTHER: begin
          sum = icdr_pkg::SUM_W'(nhp_r) + icdr_pkg::SUM_W'(8) + icdr_pkg::SUM_W'(hs_nxt);
          if (hs_nxt[31]) begin
            err_nxt = icdr_pkg::ERR_LEN;
          end else if (sum >= icdr_pkg::SUM_W'(icdr_pkg::END_MAX)) begin
            err_nxt = icdr_pkg::ERR_LEN;
          end else begin
            chunk_end = sum[icdr_pkg::END_W-1:0];
            if (phase_nxt == icdr_pkg::PH_LEN_FORM) begin
              nhp_nxt   = chunk_end;
              phase_nxt = icdr_pkg::PH_FORMID;
            end else begin
              if (phase_nxt == icdr_pkg::PH_LEN_INFO) begin
                info_pend_nxt = 1'b1;
                info_pos_nxt  = posx + icdr_pkg::END_W'(1);
              end
              gn   = 1'b1;
              gn_t = icdr_pkg::pad_even(chunk_end);
            end
          end
        end
        icdr_pkg::PH_FORMID: begin
          if (hs_nxt == icdr_pkg::FORM_A || hs_nxt == icdr_pkg::FORM_B) begin
            if (level_r >= icdr_pkg::LVL_W'(icdr_pkg::MAX_DEPTH)) begin
              err_nxt = icdr_pkg::ERR_DEEP;
            end else begin
              push = 1'b1;
              gn   = 1'b1;
              gn_t = icdr_pkg::pad_even(posx + icdr_pkg::END_W'(1));
            end
          end else begin
            gn   = 1'b1;
            gn_t = pad_nhp;
          end
        end
        default: begin
          phase_nxt = icdr_pkg::PH_WAIT;
        end
      endcase
    end

    // close every form the next header reaches, then check for a backward jump
    cand_lvl   = push ? level_r + icdr_pkg::LVL_W'(1) : level_r;
    cand_top   = push ? new_entry : top_r;
    pop        = (cand_lvl != '0) && (gn_t >= cand_top.end_pos);
    tt         = pop ? cand_top.chain_pos : gn_t;
    new_lvl    = pop ? cand_top.chain_lvl : cand_lvl;
    stk_rd_idx = icdr_pkg::IDX_W'(cand_top.chain_lvl - icdr_pkg::LVL_W'(1));
    if (gn) begin
      level_nxt = new_lvl;
      top_nxt   = pop ? stk_rd : cand_top;
      if (tt <= posx) begin
        err_nxt = icdr_pkg::ERR_LEN;
      end else begin
        nhp_nxt   = tt;
        phase_nxt = icdr_pkg::PH_WAIT;
        hcnt_nxt  = 2'd0;
      end
    end

    // flag a file that ends inside a header or an open form
    if (s1_last_r && err_nxt == icdr_pkg::ERR_NONE &&
        (phase_nxt != icdr_pkg::PH_WAIT || level_nxt != '0)) begin
      err_nxt = icdr_pkg::ERR_END;
    end

    stk_wr.en    = s1_adv && push;
    stk_wr.idx   = level_r[icdr_pkg::IDX_W-1:0];
    stk_wr.entry = new_entry;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_v_r <= in_chan.valid;
    end
    if (in_chan.valid && in_chan.ready) begin
      s1_byte_r <= in_chan.in_byte;
      s1_last_r <= in_chan.last_byte;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_v_r <= 1'b0;
    end
    if (s1_adv) begin
      out_byte_r <= byte_nxt;
      out_rep_r  <= rep_nxt;
      out_err_r  <= err_nxt;
      out_end_r  <= s1_last_r;
    end
  end

  // resolution register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dpi_r <= icdr_pkg::DPI_RESET;
    end else if (cfg_chan.valid) begin
      dpi_r <= cfg_chan.new_dpi;
    end
  end

  // parser state: commit per item, restart after the final byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      hs_r        <= '0;
      phase_r     <= icdr_pkg::PH_WAIT;
      hcnt_r      <= 2'd0;
      nhp_r       <= '0;
      level_r     <= '0;
      info_pend_r <= 1'b0;
      err_r       <= icdr_pkg::ERR_NONE;
    end else if (s1_adv) begin
      if (s1_last_r) begin
        pos_r       <= '0;
        hs_r        <= '0;
        phase_r     <= icdr_pkg::PH_WAIT;
        hcnt_r      <= 2'd0;
        nhp_r       <= '0;
        level_r     <= '0;
        info_pend_r <= 1'b0;
        err_r       <= icdr_pkg::ERR_NONE;
      end else begin
        if (pos_r != icdr_pkg::POS_MAX) begin
          pos_r <= pos_r + icdr_pkg::POS_W'(1);
        end
        hs_r        <= hs_nxt;
        phase_r     <= phase_nxt;
        hcnt_r      <= hcnt_nxt;
        nhp_r       <= nhp_nxt;
        level_r     <= level_nxt;
        info_pend_r <= info_pend_nxt;
        err_r       <= err_nxt;
      end
    end
  end

  // payload of parser state
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      top_r      <= top_nxt;
      info_pos_r <= info_pos_nxt;
    end
  end

  // checks
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= icdr_pkg::LVL_W'(icdr_pkg::MAX_DEPTH))
    else $error("stack level beyond depth");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_last_r |=> pos_r == '0 && level_r == '0 &&
      err_r == icdr_pkg::ERR_NONE && !info_pend_r)
    else $error("state not cleared after final byte");

  a_no_replace_after_error: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && err_r != icdr_pkg::ERR_NONE |=> !out_rep_r)
    else $error("byte replaced after an error");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_v_r && out_end_r == $past(s1_last_r))
    else $error("result register not loaded");

endmodule

// ----- test/iff_chunk_dpi_rewriter_core_tb.sv -----
// Testbench for the chunk resolution rewriter: random chunk documents checked against a predictor.
module iff_chunk_dpi_rewriter_core_tb;

  typedef struct packed {
    logic [7:0] data;
    logic       rep;
    logic [1:0] code;
    logic       fin;
  } byte_result_t;

  // Predicts every result byte and checks the block's results in order
  class dpi_rewrite_board;
    bit [11:0]                     dpi;
    bit [icdr_pkg::POS_W-1:0]      pos;
    bit [31:0]                     shift;
    icdr_pkg::phase_t              phase;
    int                            hcount;
    bit [icdr_pkg::END_W-1:0]      next_hdr;
    bit [icdr_pkg::END_W-1:0]      ends [icdr_pkg::MAX_DEPTH];
    int                            level;
    bit [icdr_pkg::END_W-1:0]      info_at;
    bit [1:0]                      err;
    byte_result_t                  expected_bytes [$];
    int unsigned                   mismatches;
    int unsigned                   checked;

    function new();
      dpi = icdr_pkg::DPI_RESET;
      mismatches = 0;
      checked = 0;
      restart();
    endfunction

    // Return the parser to the start of a document; the resolution stays
    function void restart();
      pos = '0;
      shift = '0;
      phase = icdr_pkg::PH_WAIT;
      hcount = 0;
      next_hdr = '0;
      foreach (ends[i]) ends[i] = '0;
      level = 0;
      info_at = icdr_pkg::END_MAX;
      err = icdr_pkg::ERR_NONE;
    endfunction

    function void set_dpi(bit [11:0] v);
      dpi = v;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    function bit [63:0] even_up(bit [63:0] x);
      return x + 64'(x[0]);
    endfunction

    // Jump to the next header at t, popping every form whose end t has reached
    function void leave_header(bit [63:0] t, bit [63:0] p);
      while (level > 0 && t >= 64'(ends[level-1])) begin
        t = even_up(64'(ends[level-1]));
        level--;
      end
      if (t <= p) begin
        err = icdr_pkg::ERR_LEN;
        return;
      end
      next_hdr = t[icdr_pkg::END_W-1:0];
      phase = icdr_pkg::PH_WAIT;
      hcount = 0;
    endfunction

    // Feed one byte (after replacement) to the header walker
    function void walk_header_byte(bit [7:0] b, bit [63:0] p);
      bit [63:0] fin;
      if (phase == icdr_pkg::PH_WAIT) begin
        if (p != 64'(next_hdr)) return;
        phase = icdr_pkg::PH_ID;
        hcount = 0;
        shift = '0;
      end
      shift = {shift[23:0], b};
      hcount++;
      if (hcount < 4) return;
      hcount = 0;
      case (phase)
        icdr_pkg::PH_ID: begin
          if (shift == icdr_pkg::ID_MAGIC) leave_header(even_up(p + 64'd1), p);
          else if (shift == icdr_pkg::ID_FORM) phase = icdr_pkg::PH_LEN_FORM;
          else if (shift == icdr_pkg::ID_INFO) phase = icdr_pkg::PH_LEN_INFO;
          else phase = icdr_pkg::PH_LEN_OTHER;
        end
        icdr_pkg::PH_LEN_FORM, icdr_pkg::PH_LEN_INFO, icdr_pkg::PH_LEN_OTHER: begin
          if (shift[31]) begin
            err = icdr_pkg::ERR_LEN;
            return;
          end
          fin = 64'(next_hdr) + 64'd8 + 64'(shift);
          if (even_up(fin) > 64'(icdr_pkg::END_MAX)) begin
            err = icdr_pkg::ERR_LEN;
            return;
          end
          if (phase == icdr_pkg::PH_LEN_FORM) begin
            next_hdr = fin[icdr_pkg::END_W-1:0];
            phase = icdr_pkg::PH_FORMID;
          end else begin
            if (phase == icdr_pkg::PH_LEN_INFO) info_at = icdr_pkg::END_W'(p + 64'd1);
            leave_header(even_up(fin), p);
          end
        end
        icdr_pkg::PH_FORMID: begin
          fin = 64'(next_hdr);
          if (shift == icdr_pkg::FORM_A || shift == icdr_pkg::FORM_B) begin
            if (level >= icdr_pkg::MAX_DEPTH) begin
              err = icdr_pkg::ERR_DEEP;
              return;
            end
            ends[level] = fin[icdr_pkg::END_W-1:0];
            level++;
            leave_header(even_up(p + 64'd1), p);
          end else begin
            leave_header(even_up(fin), p);
          end
        end
        default: phase = icdr_pkg::PH_WAIT;
      endcase
    endfunction

    // Note an accepted input byte and queue the result it must give
    function void take_byte(bit [7:0] b, bit last);
      bit [63:0]    p;
      bit [63:0]    lo;
      bit [63:0]    hi;
      bit [7:0]     v;
      bit           rep;
      byte_result_t r;
      p = 64'(pos);
      v = b;
      rep = 1'b0;
      if (err == icdr_pkg::ERR_NONE && info_at != icdr_pkg::END_MAX) begin
        lo = 64'(info_at) + 64'd6;
        hi = 64'(info_at) + 64'd7;
        if (last && hi > p) begin
          err = icdr_pkg::ERR_END;
        end else if (p == lo) begin
          v = dpi[7:0];
          rep = 1'b1;
        end else if (p == hi) begin
          v = {4'h0, dpi[11:8]};
          rep = 1'b1;
          info_at = icdr_pkg::END_MAX;
        end else if (p > hi) begin
          info_at = icdr_pkg::END_MAX;
        end
      end
      if (err == icdr_pkg::ERR_NONE) walk_header_byte(v, p);
      if (last && err == icdr_pkg::ERR_NONE &&
          (phase != icdr_pkg::PH_WAIT || level > 0)) err = icdr_pkg::ERR_END;
      r.data = v;
      r.rep = rep;
      r.code = err;
      r.fin = last;
      expected_bytes.push_back(r);
      if (last) restart();
      else if (pos != icdr_pkg::POS_MAX) pos++;
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 100) $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // Compare one result with the oldest prediction, field by field
    task check_byte(logic [7:0] d, logic rep, logic [1:0] code, logic fin);
      byte_result_t e;
      if (expected_bytes.size() == 0) begin
        report($sformatf("result byte %02h with none expected", d));
        return;
      end
      e = expected_bytes.pop_front();
      if (d !== e.data)
        report($sformatf("result %0d: out_byte %02h, want %02h", checked, d, e.data));
      if (rep !== e.rep)
        report($sformatf("result %0d: replaced %b, want %b", checked, rep, e.rep));
      if (code !== e.code)
        report($sformatf("result %0d: error_code %0d, want %0d", checked, code, e.code));
      if (fin !== e.fin)
        report($sformatf("result %0d: end_flag %b, want %b", checked, fin, e.fin));
      checked++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  icdr_in_if  in_chan ();
  icdr_out_if out_chan ();
  icdr_cfg_if cfg_chan ();

  iff_chunk_dpi_rewriter_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  dpi_rewrite_board board;
  logic [7:0]  doc [$];
  int          form_marks [$];
  bit          feed_calm;
  int unsigned sent_bytes;

  always #5 clk = ~clk;

  function automatic int idle_len();
    if ($urandom_range(0, 4) != 0) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 30));
  endfunction

  // Document building: big-endian words, chunks and nested forms
  function automatic void put_word(logic [31:0] w);
    doc.push_back(w[31:24]);
    doc.push_back(w[23:16]);
    doc.push_back(w[15:8]);
    doc.push_back(w[7:0]);
  endfunction

  function automatic void open_form();
    form_marks.push_back(doc.size());
    put_word(icdr_pkg::ID_FORM);
    put_word(32'd0);
    put_word(($urandom_range(0, 1) == 0) ? icdr_pkg::FORM_A : icdr_pkg::FORM_B);
  endfunction

  // Patch the length of the innermost open form
  function automatic void close_form();
    int          at;
    logic [31:0] len;
    at = form_marks.pop_back();
    len = 32'(doc.size() - at - 8);
    doc[at+4] = len[31:24];
    doc[at+5] = len[23:16];
    doc[at+6] = len[15:8];
    doc[at+7] = len[7:0];
  endfunction

  function automatic void put_chunk();
    int          r;
    int          len;
    logic [31:0] id;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      put_word(icdr_pkg::ID_MAGIC);
      return;
    end
    if (r < 45) begin
      id = icdr_pkg::ID_INFO;
      len = ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 16)) : 10;
    end else if (r < 55) begin
      // form of a foreign type: skipped whole
      id = icdr_pkg::ID_FORM;
      len = $urandom_range(4, 12);
    end else begin
      id = $urandom;
      len = $urandom_range(0, 12);
    end
    put_word(id);
    put_word(32'(len));
    repeat (len) doc.push_back(8'($urandom));
    if (len % 2 == 1) doc.push_back(8'($urandom));
  endfunction

  // Build one document: mostly well formed, some noise, some deliberately broken
  function automatic void build_document();
    int kind;
    int r;
    int cap;
    int len_at;
    doc.delete();
    form_marks.delete();
    kind = $urandom_range(0, 99);
    if (kind < 6) begin
      repeat ($urandom_range(1, 20)) doc.push_back(8'($urandom));
      return;
    end
    if ($urandom_range(0, 9) != 0) put_word(icdr_pkg::ID_MAGIC);
    len_at = doc.size() + 4;
    open_form();
    if (kind < 14) begin
      // nest to one below the stack limit, right up to it, or one past it
      repeat ($urandom_range(icdr_pkg::MAX_DEPTH - 2, icdr_pkg::MAX_DEPTH)) open_form();
      put_chunk();
    end else begin
      cap = $urandom_range(1, 4);
      repeat ($urandom_range(1, 8)) begin
        r = $urandom_range(0, 99);
        if (r < 20 && form_marks.size() < cap) open_form();
        else if (r < 35 && form_marks.size() > 1) close_form();
        else put_chunk();
      end
    end
    while (form_marks.size() > 0) close_form();
    r = $urandom_range(0, 99);
    if (r < 10) begin
      repeat ($urandom_range(1, doc.size() - 1)) void'(doc.pop_back());
    end else if (r < 14) begin
      doc[$urandom_range(0, doc.size() - 1)] = 8'($urandom);
    end else if (r < 17) begin
      doc[len_at] = doc[len_at] | 8'h80;
    end else if (r < 20) begin
      // form too short to hold its own type
      doc[len_at] = 8'h00;
      doc[len_at+1] = 8'h00;
      doc[len_at+2] = 8'h00;
      doc[len_at+3] = 8'($urandom_range(0, 3));
    end
  endfunction

  // Offer one byte and hold it until taken
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = feed_calm ? 0 : (($urandom_range(0, 3) == 0) ? idle_len() : 0);
    @(negedge clk);
    if (gap > 0) begin
      in_chan.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid = 1'b1;
    in_chan.in_byte = b;
    in_chan.last_byte = fin;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    sent_bytes++;
  endtask

  task automatic send_document();
    feed_calm = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < doc.size(); i++) send_byte(doc[i], i == doc.size() - 1);
  endtask

  // Stop feeding and wait until every predicted result has come back
  task automatic drain();
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_dpi(input logic [11:0] v);
    @(negedge clk);
    cfg_chan.valid = 1'b1;
    cfg_chan.new_dpi = v;
    do @(posedge clk); while (cfg_chan.ready !== 1'b1);
    @(negedge clk);
    cfg_chan.valid = 1'b0;
  endtask

  // Result side: random stalls, with calm stretches
  initial begin : result_sink
    int stall;
    bit calm;
    stall = 0;
    calm = 1'b0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 299) == 0) calm = !calm;
      if (stall > 0) begin
        out_chan.ready = 1'b0;
        stall--;
      end else begin
        out_chan.ready = 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) stall = idle_len();
      end
    end
  end

  // Sample every handshake at the rising edge
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (cfg_chan.valid === 1'b1 && cfg_chan.ready === 1'b1) board.set_dpi(cfg_chan.new_dpi);
      if (in_chan.valid === 1'b1 && in_chan.ready === 1'b1)
        board.take_byte(in_chan.in_byte, in_chan.last_byte);
      if (out_chan.valid === 1'b1 && out_chan.ready === 1'b1)
        board.check_byte(out_chan.out_byte, out_chan.replaced, out_chan.error_code,
                         out_chan.end_flag);
    end
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [11:0] dpi_plan [6];
    int unsigned phase_start;
    board = new();
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.in_byte = 8'h00;
    in_chan.last_byte = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.new_dpi = 12'h000;
    feed_calm = 1'b1;
    sent_bytes = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: one-byte documents, a negative length, a bare info chunk
    doc = '{8'hff};
    send_document();
    doc = '{8'h00};
    send_document();
    doc.delete();
    put_word(icdr_pkg::ID_FORM);
    put_word(32'hffffffff);
    send_document();
    doc.delete();
    put_word(icdr_pkg::ID_INFO);
    put_word(32'd8);
    put_word(32'h00ff807f);
    put_word(32'h01feaa55);
    send_document();

    // Random documents under a series of resolutions, extremes included
    dpi_plan = '{12'd25, 12'd2400, 12'h000, 12'hfff, 12'($urandom),
                 12'($urandom_range(25, 2400))};
    foreach (dpi_plan[k]) begin
      drain();
      write_dpi(dpi_plan[k]);
      phase_start = sent_bytes;
      while (sent_bytes - phase_start < 280) begin
        build_document();
        send_document();
      end
    end
    drain();
    repeat (6) @(posedge clk);

    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
